/* sv/smp_pkg.sv */
// ----------------------------------------------------------------------------
// smp_pkg: shared types and constants of the servo motion profile block
// Register indexes, reset values, field widths and the controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package smp_pkg;

	localparam int GOAL_W   = 10;
	localparam int POS_W    = 11;
	localparam int DIST_W   = 10;
	localparam int SPEED_W  = 6;
	localparam int NSPD_W   = 7;
	localparam int MOVE_W   = 7;
	localparam int PWM_W    = 13;
	localparam int HOME_W   = 12;
	localparam int ACCEL_W  = 3;
	localparam int THR_W    = 4;
	localparam int RAD_W    = 14;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;

	localparam logic [CFG_IDX_W-1:0] CFG_HOME_TIME      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_STEP     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_NEAR_THRESHOLD = 2'd3;

	localparam logic [HOME_W-1:0]  HOME_RST  = 12'd1500;
	localparam logic [SPEED_W-1:0] MAXSP_RST = 6'd30;
	localparam logic [ACCEL_W-1:0] ACCEL_RST = 3'd2;
	localparam logic [THR_W-1:0]   THR_RST   = 4'd4;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;       // capture the goal of an accepted transaction
		logic prod;       // distance and radicand
		logic root_step;  // one bit of the square root
		logic move;       // speed clamp, step and move
		logic apply;      // commit state and load the result register
	} smp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic zero_diff;  // already at the goal
		logic root_last;  // current root step resolves bit zero
	} smp_sts_t;

endpackage

/* sv/smp_goal_if.sv */
// ----------------------------------------------------------------------------
// smp_goal_if: input channel of the servo motion profile block
// Valid/ready channel carrying the signed goal offset of one control tick.
// ----------------------------------------------------------------------------
interface smp_goal_if;
	logic              valid;
	logic              ready;
	logic signed [9:0] goal_offset;

	modport source (output valid, output goal_offset, input ready);
	modport sink (input valid, input goal_offset, output ready);
endinterface

/* sv/smp_result_if.sv */
// ----------------------------------------------------------------------------
// smp_result_if: result channel of the servo motion profile block
// Valid/ready channel carrying PWM time, position, speed and goal flag.
// ----------------------------------------------------------------------------
interface smp_result_if;
	logic              valid;
	logic              ready;
	logic [12:0]       pwm_high_time;
	logic signed [9:0] position_out;
	logic [5:0]        speed_out;
	logic              at_goal;

	modport source (output valid, output pwm_high_time, output position_out,
		output speed_out, output at_goal, input ready);
	modport sink (input valid, input pwm_high_time, input position_out,
		input speed_out, input at_goal, output ready);
endinterface

/* sv/smp_datapath.sv */
// ----------------------------------------------------------------------------
// smp_datapath: arithmetic and state of the servo motion profile
// Holds configuration, position and speed, runs the bit-serial square root
// and computes the move of one tick under the controller's commands.
// ----------------------------------------------------------------------------
module smp_datapath
	import smp_pkg::*;
#(
	parameter int ROOT_BITS = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  smp_cmd_t               cmd,
	output smp_sts_t               sts,
	input  logic signed [GOAL_W-1:0] goal_offset,
	input  logic                   cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output logic [PWM_W-1:0]       pwm_high_time,
	output logic signed [GOAL_W-1:0] position_out,
	output logic [SPEED_W-1:0]     speed_out,
	output logic                   at_goal
);

	localparam int SQ_W = (2 * ROOT_BITS > RAD_W) ? 2 * ROOT_BITS : RAD_W;
	localparam int CW   = (ROOT_BITS + 1 > SPEED_W) ? ROOT_BITS + 1 : SPEED_W;

	// Configuration registers.
	logic [HOME_W-1:0]  home_q;
	logic [SPEED_W-1:0] maxsp_q;
	logic [ACCEL_W-1:0] accel_q;
	logic [THR_W-1:0]   thr_q;

	// Motion state.
	logic signed [POS_W-1:0] pos_q;
	logic [SPEED_W-1:0]      speed_q;

	// Per-tick working registers.
	logic signed [GOAL_W-1:0] goal_q;
	logic                     dir_q;
	logic                     zero_q;
	logic [DIST_W-1:0]        dist_q;
	logic [RAD_W-1:0]         rad_q;
	logic [ROOT_BITS-1:0]     root_q;
	logic [ROOT_BITS-1:0]     mask_q;
	logic [NSPD_W-1:0]        nspd_q;
	logic [MOVE_W-1:0]        move_q;

	// Distance stage.
	logic signed [POS_W-1:0] goal_ext;
	logic signed [POS_W-1:0] diff;
	logic [POS_W-1:0]        diff_abs;
	logic [RAD_W-1:0]        rad;

	assign goal_ext = {goal_q[GOAL_W-1], goal_q};
	assign diff     = goal_ext - pos_q;
	assign diff_abs = diff[POS_W-1] ? POS_W'(-diff) : POS_W'(diff);
	assign rad      = RAD_W'({accel_q, 1'b0}) * RAD_W'(diff_abs[DIST_W-1:0]);

	// Root stage.
	logic [ROOT_BITS-1:0]   trial;
	logic [2*ROOT_BITS-1:0] trial_sq;

	assign trial    = root_q | mask_q;
	assign trial_sq = trial * trial;

	// Move stage.
	logic [CW-1:0]      spd_w, lim_w, lim1_w;
	logic [SPEED_W-1:0] spd_c, headroom;
	logic [ACCEL_W-1:0] step;
	logic               accelerate;
	logic [NSPD_W-1:0]  nspd;
	logic [MOVE_W-1:0]  mv, mv_clip;

	always_comb begin
		spd_w  = CW'(speed_q);
		lim_w  = CW'(root_q);
		lim1_w = lim_w + CW'(1);
		spd_c  = (spd_w > lim1_w) ? lim1_w[SPEED_W-1:0] : speed_q;
		accelerate = CW'(spd_c) < lim_w;
		headroom = (maxsp_q > spd_c) ? maxsp_q - spd_c : '0;
		if (accelerate) begin
			step = (headroom > SPEED_W'(accel_q)) ? accel_q : headroom[ACCEL_W-1:0];
			nspd = NSPD_W'(spd_c) + NSPD_W'(step);
			mv   = MOVE_W'(spd_c) + MOVE_W'(step >> 1);
		end else begin
			step = (spd_c < SPEED_W'(accel_q)) ? spd_c[ACCEL_W-1:0] : accel_q;
			nspd = NSPD_W'(spd_c) - NSPD_W'(step);
			mv   = MOVE_W'(spd_c) - MOVE_W'(step >> 1);
		end
		mv_clip = (DIST_W'(mv) > dist_q) ? dist_q[MOVE_W-1:0] : mv;
	end

	// Apply stage.
	logic signed [POS_W-1:0] mv_s, pos_step, pos_nx;
	logic [DIST_W-1:0]       rem;
	logic                    snap;
	logic [NSPD_W-1:0]       spd_raw;
	logic [SPEED_W-1:0]      spd_nx;
	logic signed [PWM_W:0]   pwm_sum;

	always_comb begin
		mv_s     = signed'({{(POS_W-MOVE_W){1'b0}}, move_q});
		pos_step = dir_q ? pos_q + mv_s : pos_q - mv_s;
		rem      = dist_q - DIST_W'(move_q);
		snap     = rem < DIST_W'(thr_q);
		spd_raw  = snap ? '0 : nspd_q;
		if (zero_q) begin
			pos_nx = pos_q;
			spd_nx = speed_q;
		end else begin
			pos_nx = snap ? goal_ext : pos_step;
			spd_nx = (spd_raw > NSPD_W'(maxsp_q)) ? maxsp_q : spd_raw[SPEED_W-1:0];
		end
		pwm_sum = signed'({2'b00, home_q}) + {{(PWM_W+1-POS_W){pos_nx[POS_W-1]}}, pos_nx};
	end

	assign sts.zero_diff = zero_q;
	assign sts.root_last = mask_q[0];

	// Control-relevant state: configuration and motion state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			home_q  <= HOME_RST;
			maxsp_q <= MAXSP_RST;
			accel_q <= ACCEL_RST;
			thr_q   <= THR_RST;
			pos_q   <= '0;
			speed_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_HOME_TIME:      home_q  <= cfg_data[HOME_W-1:0];
					CFG_MAX_SPEED:      maxsp_q <= cfg_data[SPEED_W-1:0];
					CFG_ACCEL_STEP:     accel_q <= cfg_data[ACCEL_W-1:0];
					CFG_NEAR_THRESHOLD: thr_q   <= cfg_data[THR_W-1:0];
					default: ;
				endcase
			end
			if (cmd.apply) begin
				pos_q   <= pos_nx;
				speed_q <= spd_nx;
			end
		end
	end

	// Working and result payload registers.
	always_ff @(posedge clk) begin
		if (cmd.load)
			goal_q <= goal_offset;
		if (cmd.prod) begin
			dir_q  <= ~diff[POS_W-1];
			zero_q <= (diff == '0);
			dist_q <= diff_abs[DIST_W-1:0];
			rad_q  <= rad;
			root_q <= '0;
			mask_q <= {1'b1, {(ROOT_BITS-1){1'b0}}};
		end
		if (cmd.root_step) begin
			if (SQ_W'(trial_sq) <= SQ_W'(rad_q))
				root_q <= trial;
			mask_q <= mask_q >> 1;
		end
		if (cmd.move) begin
			nspd_q <= nspd;
			move_q <= mv_clip;
		end
		if (cmd.apply) begin
			pwm_high_time <= pwm_sum[PWM_W] ? '0 : pwm_sum[PWM_W-1:0];
			position_out  <= pos_nx[GOAL_W-1:0];
			speed_out     <= spd_nx;
			at_goal       <= (pos_nx == goal_ext);
		end
	end

endmodule

/* sv/smp_ctrl.sv */
// ----------------------------------------------------------------------------
// smp_ctrl: sequencing controller of the servo motion profile
// Steps one tick through distance, square root, move and commit, and owns
// the handshakes of both channels.
// ----------------------------------------------------------------------------
module smp_ctrl
	import smp_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output smp_cmd_t cmd,
	input  smp_sts_t sts
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_PROD  = 3'd1;
	localparam logic [2:0] ST_ROOT  = 3'd2;
	localparam logic [2:0] ST_MOVE  = 3'd3;
	localparam logic [2:0] ST_APPLY = 3'd4;

	logic [2:0] state_q, state_nx;
	logic       out_valid_q;
	logic       slot_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		cmd = '0;
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				cmd.load = in_valid;
				if (in_valid)
					state_nx = ST_PROD;
			end
			ST_PROD: begin
				cmd.prod = 1'b1;
				state_nx = ST_ROOT;
			end
			ST_ROOT: begin
				if (sts.zero_diff) begin
					state_nx = ST_APPLY;
				end else begin
					cmd.root_step = 1'b1;
					if (sts.root_last)
						state_nx = ST_MOVE;
				end
			end
			ST_MOVE: begin
				cmd.move = 1'b1;
				state_nx = ST_APPLY;
			end
			ST_APPLY: begin
				cmd.apply = slot_free;
				if (slot_free)
					state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.apply)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

`ifndef SYNTH
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second transaction accepted while one is in flight");
	a_apply_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.apply |=> out_valid)
		else $error("commit did not present a result");
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.prod, cmd.root_step, cmd.move, cmd.apply}))
		else $error("more than one datapath command at once");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !cmd.apply)
		else $error("pending result overwritten");
`endif

endmodule

/* sv/servo_motion_profile.sv */
// ----------------------------------------------------------------------------
// servo_motion_profile: trapezoidal velocity profile for a hobby servo
// Each accepted transaction is one control tick carrying the goal offset; the
// block returns one result with PWM high time, position, speed and goal flag.
// ----------------------------------------------------------------------------
// Each transaction passes through the distance, square root, move and commit
// states; if the position already equals the goal, root and move are skipped.
// A new transaction is accepted only after the commit, which waits while the
// last result is pending; the square root resolves one root bit per cycle.
// Reset: position and speed clear to zero, registers take their defaults and
// no result is pending; the block is ready in the first cycle after reset.
module servo_motion_profile
	import smp_pkg::*;
#(
	parameter int ROOT_BITS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	smp_goal_if.sink              goal,
	smp_result_if.source          result,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// The controller sequences the tick and owns both handshakes; the
	// datapath holds all arithmetic, the configuration and the motion state.
	smp_cmd_t cmd;
	smp_sts_t sts;

	smp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (goal.valid),
		.in_ready  (goal.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// The result register sits in the datapath, so a new transaction can be
	// accepted while the previous result still waits to be taken. A commit
	// waits only if that result is still pending when the next one is done.
	smp_datapath #(
		.ROOT_BITS (ROOT_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.goal_offset   (goal.goal_offset),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.pwm_high_time (result.pwm_high_time),
		.position_out  (result.position_out),
		.speed_out     (result.speed_out),
		.at_goal       (result.at_goal)
	);

endmodule

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// tb: self-checking testbench of the servo motion profile block
// A directed table covers reset, the register extremes, snapping, PWM floor
// saturation, goal reversal and a lowered speed limit. Random phases follow,
// each under its own register setting. A tick-level model of the profile
// predicts each result not fixed by hand; a scoreboard checks them in order.
// ----------------------------------------------------------------------------
module tb;
	import smp_pkg::*;

	localparam int ROOT_BITS = 8;
	// Cycles without any accepted transaction before the run is declared hung.
	localparam int WATCHDOG_LIMIT = 2000;
	// Settling time after the last result, scaled with the root width.
	localparam int TAIL_CYCLES = 3 * (ROOT_BITS + 4);
	localparam int PHASES = 8;
	localparam int TICKS_PER_PHASE = 66;
	localparam int PRINT_CAP = 100;

	// One result of the block, in the field order of the result channel.
	typedef struct packed {
		logic [PWM_W-1:0]   pwm;
		logic [GOAL_W-1:0]  pos;
		logic [SPEED_W-1:0] spd;
		logic               at;
	} servo_out_t;

	typedef enum logic {ROW_TICK, ROW_CFG} row_kind_t;

	// One line of the directed table. For a tick the argument is the goal
	// offset; for a register write it is the value. Rows marked fixed carry a
	// result that is known by hand and replaces the prediction.
	typedef struct packed {
		row_kind_t              kind;
		logic [CFG_IDX_W-1:0]   reg_idx;
		int                     arg;
		logic                   fixed;
		servo_out_t             want;
	} plan_row_t;

	localparam servo_out_t NO_WANT = '0;
	localparam int PLAN_LEN = 30;
	localparam plan_row_t PLAN [PLAN_LEN] = '{
		// Out of reset the servo sits at home with no speed.
		'{ROW_TICK, '0, 0, 1'b1, '{pwm: 13'd1500, pos: 10'd0, spd: 6'd0, at: 1'b1}},
		// With home at zero, a short move snaps onto the goal and the PWM
		// time, home plus a negative position, saturates at zero.
		'{ROW_CFG, CFG_HOME_TIME, 0, 1'b0, NO_WANT},
		'{ROW_CFG, CFG_NEAR_THRESHOLD, 15, 1'b0, NO_WANT},
		'{ROW_TICK, '0, -3, 1'b1, '{pwm: 13'd0, pos: 10'h3FD, spd: 6'd0, at: 1'b1}},
		// Already at the goal: nothing moves, the result is still returned.
		'{ROW_TICK, '0, -3, 1'b1, '{pwm: 13'd0, pos: 10'h3FD, spd: 6'd0, at: 1'b1}},
		'{ROW_CFG, CFG_HOME_TIME, 4095, 1'b0, NO_WANT},
		'{ROW_TICK, '0, 0, 1'b1, '{pwm: 13'd4095, pos: 10'd0, spd: 6'd0, at: 1'b1}},
		// No snapping from here on; a long move with a reversal halfway.
		'{ROW_CFG, CFG_NEAR_THRESHOLD, 0, 1'b0, NO_WANT},
		'{ROW_CFG, CFG_HOME_TIME, 1500, 1'b0, NO_WANT},
		'{ROW_TICK, '0, 500, 1'b0, NO_WANT},
		'{ROW_TICK, '0, 500, 1'b0, NO_WANT},
		'{ROW_TICK, '0, 500, 1'b0, NO_WANT},
		'{ROW_TICK, '0, -500, 1'b0, NO_WANT},
		'{ROW_TICK, '0, -500, 1'b0, NO_WANT},
		// Fastest profile toward the largest goal the field holds.
		'{ROW_CFG, CFG_MAX_SPEED, 63, 1'b0, NO_WANT},
		'{ROW_CFG, CFG_ACCEL_STEP, 7, 1'b0, NO_WANT},
		'{ROW_TICK, '0, 511, 1'b0, NO_WANT},
		'{ROW_TICK, '0, 511, 1'b0, NO_WANT},
		'{ROW_TICK, '0, 511, 1'b0, NO_WANT},
		'{ROW_TICK, '0, 511, 1'b0, NO_WANT},
		// Speed limit lowered under the current speed, then the smallest goal.
		'{ROW_CFG, CFG_MAX_SPEED, 1, 1'b0, NO_WANT},
		'{ROW_TICK, '0, -512, 1'b0, NO_WANT},
		'{ROW_TICK, '0, -512, 1'b0, NO_WANT},
		// Zero acceleration, then zero speed limit.
		'{ROW_CFG, CFG_ACCEL_STEP, 0, 1'b0, NO_WANT},
		'{ROW_TICK, '0, 0, 1'b0, NO_WANT},
		'{ROW_TICK, '0, 0, 1'b0, NO_WANT},
		'{ROW_CFG, CFG_MAX_SPEED, 0, 1'b0, NO_WANT},
		'{ROW_CFG, CFG_ACCEL_STEP, 7, 1'b0, NO_WANT},
		'{ROW_TICK, '0, 100, 1'b0, NO_WANT},
		'{ROW_TICK, '0, 100, 1'b0, NO_WANT}
	};

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	smp_goal_if   goal_ch ();
	smp_result_if res_ch ();

	servo_motion_profile #(.ROOT_BITS(ROOT_BITS)) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.goal      (goal_ch),
		.result    (res_ch),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #10 clk = ~clk;

	// Shadow of the block's registers and motion state, kept by the predictor.
	logic [HOME_W-1:0]  shadow_home;
	logic [SPEED_W-1:0] shadow_max_speed;
	logic [ACCEL_W-1:0] shadow_accel;
	logic [THR_W-1:0]   shadow_near;
	logic [POS_W-1:0]   shadow_pos;
	logic [NSPD_W-1:0]  shadow_speed;

	// Results still owed by the block, oldest first.
	servo_out_t pending_results [$];
	int mismatches = 0;
	// While set, the sender adds no random gaps and the result side is always ready.
	bit steady = 1'b0;

	// Advances the shadow state by one control tick and returns the result
	// that the block must report for it.
	function automatic servo_out_t advance_servo(input logic [GOAL_W-1:0] goal_raw);
		int goal, here, diff, span, rad, limit, trial, b;
		int spd, top, acc, thr, step, move, nspd, pwm;
		servo_out_t res;
		goal = int'($signed(goal_raw));
		here = int'($signed(shadow_pos));
		diff = goal - here;
		top  = int'(shadow_max_speed);
		acc  = int'(shadow_accel);
		thr  = int'(shadow_near);
		if (diff != 0) begin
			span = (diff < 0) ? -diff : diff;
			// Braking limit: bit-serial integer square root of 2*accel*distance.
			rad = 2 * acc * span;
			limit = 0;
			for (b = ROOT_BITS - 1; b >= 0; b--) begin
				trial = limit | (1 << b);
				if (trial * trial <= rad)
					limit = trial;
			end
			spd = int'(shadow_speed);
			if (spd > limit + 1)
				spd = limit + 1;
			if (spd < limit) begin
				// Accelerate; the step saturates at zero when speed is over
				// the limit register.
				step = (top > spd) ? top - spd : 0;
				if (step > acc)
					step = acc;
				nspd = spd + step;
				move = spd + step / 2;
			end else begin
				step = (spd < acc) ? spd : acc;
				nspd = spd - step;
				move = spd - step / 2;
			end
			if (move > span)
				move = span;
			here = (diff > 0) ? here + move : here - move;
			if (span - move < thr) begin
				here = goal;
				nspd = 0;
			end
			if (nspd > top)
				nspd = top;
			shadow_pos   = here[POS_W-1:0];
			shadow_speed = nspd[NSPD_W-1:0];
		end
		pwm = int'(shadow_home) + here;
		if (pwm < 0)
			pwm = 0;
		res.pwm = pwm[PWM_W-1:0];
		res.pos = here[GOAL_W-1:0];
		res.spd = shadow_speed[SPEED_W-1:0];
		res.at  = (here == goal);
		return res;
	endfunction

	// Picks the goal of a well-formed move: mostly anywhere in the servo's
	// travel, sometimes an end of the field, sometimes a short hop from the
	// current position so that the snap threshold comes into play.
	function automatic logic [GOAL_W-1:0] pick_target();
		int v;
		case ($urandom_range(9))
			0: v = $urandom_range(1) ? 511 : -512;
			1: v = $urandom_range(1) ? 500 : -500;
			2: begin
				v = int'($signed(shadow_pos)) + int'($urandom_range(30)) - 15;
				if (v > 511)
					v = 511;
				if (v < -512)
					v = -512;
			end
			default: v = int'($urandom_range(1000)) - 500;
		endcase
		return v[GOAL_W-1:0];
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		if (mismatches < PRINT_CAP)
			$display("%0t: MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
		mismatches++;
	endtask

	// Holds the sender off until the block has returned every result.
	task automatic wait_idle();
		goal_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// Writes one register once the block is idle. Bits of the write data above
	// the register's width carry random values and must be ignored.
	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input int value);
		logic [CFG_DATA_W-1:0] data;
		wait_idle();
		data = CFG_DATA_W'($urandom_range(4095));
		case (idx)
			CFG_HOME_TIME: begin
				data[HOME_W-1:0] = value[HOME_W-1:0];
				shadow_home = value[HOME_W-1:0];
			end
			CFG_MAX_SPEED: begin
				data[SPEED_W-1:0] = value[SPEED_W-1:0];
				shadow_max_speed = value[SPEED_W-1:0];
			end
			CFG_ACCEL_STEP: begin
				data[ACCEL_W-1:0] = value[ACCEL_W-1:0];
				shadow_accel = value[ACCEL_W-1:0];
			end
			CFG_NEAR_THRESHOLD: begin
				data[THR_W-1:0] = value[THR_W-1:0];
				shadow_near = value[THR_W-1:0];
			end
			default: ;
		endcase
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic apply_profile(input int home, input int top, input int acc, input int thr);
		write_register(CFG_HOME_TIME, home);
		write_register(CFG_MAX_SPEED, top);
		write_register(CFG_ACCEL_STEP, acc);
		write_register(CFG_NEAR_THRESHOLD, thr);
	endtask

	// Offers one control tick and, once the block takes it, queues the result
	// it owes. The valid line stays high between back-to-back ticks; in this task
	// it only drops for a random gap before a tick.
	task automatic send_tick(input logic [GOAL_W-1:0] target, input logic use_fixed,
		input servo_out_t fixed_out);
		servo_out_t predicted;
		if (!steady && $urandom_range(99) < 24) begin
			goal_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		goal_ch.valid       <= 1'b1;
		goal_ch.goal_offset <= target;
		do
			@(posedge clk);
		while (!goal_ch.ready);
		predicted = advance_servo(target);
		pending_results.push_back(use_fixed ? fixed_out : predicted);
	endtask

	// Result side: ready drops in about a quarter of the cycles, except
	// during the steady phase.
	initial begin
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			res_ch.ready <= steady || ($urandom_range(99) >= 24);
		end
	end

	// Scoreboard: every accepted result is matched against the oldest one owed.
	always @(posedge clk) begin
		servo_out_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result with none pending",
					int'($signed(res_ch.position_out)), 0);
			end else begin
				want = pending_results.pop_front();
				if (res_ch.pwm_high_time !== want.pwm)
					report_mismatch("pwm_high_time", int'(res_ch.pwm_high_time),
						int'(want.pwm));
				if (res_ch.position_out !== want.pos)
					report_mismatch("position_out", int'($signed(res_ch.position_out)),
						int'($signed(want.pos)));
				if (res_ch.speed_out !== want.spd)
					report_mismatch("speed_out", int'(res_ch.speed_out), int'(want.spd));
				if (res_ch.at_goal !== want.at)
					report_mismatch("at_goal", int'(res_ch.at_goal), int'(want.at));
			end
		end
	end

	// Watchdog: a run that stops moving transactions is a hang.
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if ((goal_ch.valid && goal_ch.ready) || (res_ch.valid && res_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		int i, phase, sent, hold;
		logic [GOAL_W-1:0] target;

		// Every input is known from time zero, with reset asserted first.
		arst_n              <= 1'b0;
		cfg_wr_en           <= 1'b0;
		cfg_index           <= '0;
		cfg_data            <= '0;
		goal_ch.valid       <= 1'b0;
		goal_ch.goal_offset <= '0;
		shadow_home      = HOME_RST;
		shadow_max_speed = MAXSP_RST;
		shadow_accel     = ACCEL_RST;
		shadow_near      = THR_RST;
		shadow_pos       = '0;
		shadow_speed     = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table.
		for (i = 0; i < PLAN_LEN; i++) begin
			if (PLAN[i].kind == ROW_CFG) begin
				write_register(PLAN[i].reg_idx, PLAN[i].arg);
			end else begin
				target = PLAN[i].arg[GOAL_W-1:0];
				send_tick(target, PLAN[i].fixed, PLAN[i].want);
			end
		end

		// Random phases, each under a register setting of its own. The first
		// two take the extremes, the third the reset values, and two more
		// zero out the speed limit or the acceleration.
		for (phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: apply_profile(0, 63, 7, 0);
				1: apply_profile(4095, 1, 1, 15);
				2: apply_profile(HOME_RST, MAXSP_RST, ACCEL_RST, THR_RST);
				3: apply_profile($urandom_range(4095), 0, $urandom_range(7),
					$urandom_range(15));
				5: apply_profile($urandom_range(4095), $urandom_range(63), 0,
					$urandom_range(15));
				default: apply_profile($urandom_range(4095), $urandom_range(1, 63),
					$urandom_range(1, 7), $urandom_range(15));
			endcase
			// One phase runs with no random gaps on either side.
			steady = (phase == 4);
			sent = 0;
			while (sent < TICKS_PER_PHASE) begin
				if ($urandom_range(99) < 80) begin
					// A well-formed move: the goal is held for a run of ticks so
					// the profile ramps up, cruises and brakes.
					target = pick_target();
					hold = $urandom_range(1, 24);
					if (hold > TICKS_PER_PHASE - sent)
						hold = TICKS_PER_PHASE - sent;
					repeat (hold) begin
						send_tick(target, 1'b0, NO_WANT);
						sent++;
					end
				end else begin
					send_tick(GOAL_W'($urandom_range(1023)), 1'b0, NO_WANT);
					sent++;
				end
				if ($urandom_range(99) < 4)
					wait_idle();
			end
		end
		steady = 1'b0;

		// Drain, then give the block time to show any result it should not.
		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
